// File: sv/lrucc_pkg.sv
`default_nettype none
package lrucc_pkg;

	localparam int unsigned KEY_W    = 64;
	localparam int unsigned HANDLE_W = 32;
	localparam int unsigned BYTES_W  = 20;
	localparam int unsigned TOTAL_W  = 32;
	localparam int unsigned CAP_W    = 16;
	localparam int unsigned KB_SHIFT = 10;
	localparam int unsigned IN_TDATA_W  = 120;
	localparam int unsigned OUT_TDATA_W = 152;

	localparam logic OP_LOOKUP = 1'b0;
	localparam logic OP_STORE  = 1'b1;

	localparam logic [CAP_W-1:0] CAP_RESET = 16'd1024;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DECIDE,
		ST_HIT_RD,
		ST_HIT_FIX,
		ST_HIT_LINK,
		ST_EV_RD,
		ST_EV_FIX,
		ST_INS,
		ST_DONE
	} state_t;

endpackage
`default_nettype wire

// File: sv/lru_content_cache.sv
`default_nettype none
// Channel   | Direction | Payload
// s_axis    | in        | tuser: operation; tdata: key, data_handle, data_bytes
// m_axis    | out       | tuser: hit, evicted; tdata: hit_handle, hit_bytes,
//           |           |        evicted_key, replacement_count
// cfg       | in        | capacity_kb
//
// One request runs from its transfer to the next input transfer in these steps:
// the key search over all ENTRIES slots, one per cycle, then drain, decide,
// the list-link reads and writes, load result, idle.
// The result sits in an output register; the next request is taken while it
// waits. Reset (arst_n low) empties the cache at once; no clearing pass.
// A stalled m_axis holds the block in its final step until the register frees.
module lru_content_cache #(
	parameter int unsigned ENTRIES = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [119:0] s_axis_tdata,  // key[63:0], data_handle, data_bytes, pad
	input  wire logic [0:0]  s_axis_tuser,   // operation
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [151:0]     m_axis_tdata,   // hit_handle, hit_bytes, evicted_key,
	                                         // replacement_count, pad
	output logic [1:0]       m_axis_tuser,   // hit, evicted
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [15:0] cfg_data
);

	localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int unsigned CW = $clog2(ENTRIES + 1);
	localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);
	localparam int unsigned DW = lrucc_pkg::HANDLE_W + lrucc_pkg::BYTES_W;

	lrucc_pkg::state_t state_q, state_nx;

	logic [lrucc_pkg::CAP_W-1:0]    cap_q;
	logic                           op_q;
	logic [lrucc_pkg::KEY_W-1:0]    key_q;
	logic [lrucc_pkg::HANDLE_W-1:0] handle_q;
	logic [lrucc_pkg::BYTES_W-1:0]  bytes_q;

	logic [ENTRIES-1:0] valid_q;
	logic [AW-1:0]      mru_q, lru_q;
	logic [CW-1:0]      count_q;
	logic [lrucc_pkg::TOTAL_W-1:0] total_q, repl_q;

	logic [AW-1:0] cnt_q, idx_s1, slot_q, free_q;
	logic          cmp_s1, found_q, free_found_q;

	logic                           res_hit_q, res_ev_q;
	logic [lrucc_pkg::HANDLE_W-1:0] res_handle_q;
	logic [lrucc_pkg::BYTES_W-1:0]  res_bytes_q;
	logic [lrucc_pkg::KEY_W-1:0]    res_evkey_q;

	logic                           out_valid_q, out_hit_q, out_ev_q;
	logic [lrucc_pkg::HANDLE_W-1:0] out_handle_q;
	logic [lrucc_pkg::BYTES_W-1:0]  out_bytes_q;
	logic [lrucc_pkg::KEY_W-1:0]    out_evkey_q;
	logic [lrucc_pkg::TOTAL_W-1:0]  out_repl_q;

	// memory ports
	logic                         key_we, dat_we, old_we, new_we;
	logic [AW-1:0]                key_ra, dat_ra, old_ra, new_ra;
	logic [AW-1:0]                old_wa, new_wa;
	logic [lrucc_pkg::KEY_W-1:0]  key_rd;
	logic [DW-1:0]                dat_rd;
	logic [AW-1:0]                old_wd, new_wd, old_rd, new_rd;

	logic in_xfer, out_load, match, bytes_full, evict_now;
	logic [lrucc_pkg::TOTAL_W:0] sum;

	assign s_axis_tready = (state_q == lrucc_pkg::ST_IDLE);
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;
	assign out_load      = (state_q == lrucc_pkg::ST_DONE) && (!out_valid_q || m_axis_tready);
	assign match         = cmp_s1 && valid_q[idx_s1] && (key_rd == key_q);
	assign bytes_full    = total_q >= {6'd0, cap_q, 10'd0};
	assign evict_now     = (count_q != '0) && (bytes_full || count_q >= CW'(ENTRIES));
	assign sum           = {1'b0, total_q} + {13'd0, bytes_q};

	lrucc_ram #(.W(lrucc_pkg::KEY_W), .D(ENTRIES)) u_key_ram (
		.clk(clk), .we(key_we), .waddr(free_q), .wdata(key_q), .raddr(key_ra), .rdata(key_rd)
	);
	lrucc_ram #(.W(DW), .D(ENTRIES)) u_dat_ram (
		.clk(clk), .we(dat_we), .waddr(free_q), .wdata({bytes_q, handle_q}),
		.raddr(dat_ra), .rdata(dat_rd)
	);
	lrucc_ram #(.W(AW), .D(ENTRIES)) u_old_ram (
		.clk(clk), .we(old_we), .waddr(old_wa), .wdata(old_wd), .raddr(old_ra), .rdata(old_rd)
	);
	lrucc_ram #(.W(AW), .D(ENTRIES)) u_new_ram (
		.clk(clk), .we(new_we), .waddr(new_wa), .wdata(new_wd), .raddr(new_ra), .rdata(new_rd)
	);

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			lrucc_pkg::ST_IDLE:     if (in_xfer) state_nx = lrucc_pkg::ST_SCAN;
			lrucc_pkg::ST_SCAN:     if (cnt_q == LAST) state_nx = lrucc_pkg::ST_DRAIN;
			lrucc_pkg::ST_DRAIN:    state_nx = lrucc_pkg::ST_DECIDE;
			lrucc_pkg::ST_DECIDE: begin
				if (found_q) state_nx = lrucc_pkg::ST_HIT_RD;
				else if (op_q == lrucc_pkg::OP_STORE)
					state_nx = evict_now ? lrucc_pkg::ST_EV_RD : lrucc_pkg::ST_INS;
				else state_nx = lrucc_pkg::ST_DONE;
			end
			lrucc_pkg::ST_HIT_RD:   state_nx = lrucc_pkg::ST_HIT_FIX;
			lrucc_pkg::ST_HIT_FIX:
				state_nx = (slot_q == mru_q) ? lrucc_pkg::ST_DONE : lrucc_pkg::ST_HIT_LINK;
			lrucc_pkg::ST_HIT_LINK: state_nx = lrucc_pkg::ST_DONE;
			lrucc_pkg::ST_EV_RD:    state_nx = lrucc_pkg::ST_EV_FIX;
			lrucc_pkg::ST_EV_FIX:   state_nx = lrucc_pkg::ST_INS;
			lrucc_pkg::ST_INS:      state_nx = lrucc_pkg::ST_DONE;
			lrucc_pkg::ST_DONE:     if (out_load) state_nx = lrucc_pkg::ST_IDLE;
			default:                state_nx = lrucc_pkg::ST_IDLE;
		endcase
	end

	// memory controls
	always_comb begin
		key_we = 1'b0; dat_we = 1'b0; old_we = 1'b0; new_we = 1'b0;
		key_ra = cnt_q; dat_ra = slot_q; old_ra = slot_q; new_ra = slot_q;
		old_wa = slot_q; old_wd = mru_q;
		new_wa = mru_q;  new_wd = slot_q;
		unique case (state_q)
			lrucc_pkg::ST_HIT_FIX: begin
				// unlink from the middle of the list
				if (slot_q != mru_q && slot_q != lru_q) begin
					new_we = 1'b1; new_wa = old_rd; new_wd = new_rd;
					old_we = 1'b1; old_wa = new_rd; old_wd = old_rd;
				end
			end
			lrucc_pkg::ST_HIT_LINK: begin
				old_we = 1'b1;
				new_we = 1'b1;
			end
			lrucc_pkg::ST_EV_RD: begin
				key_ra = lru_q;
				new_ra = lru_q;
			end
			lrucc_pkg::ST_INS: begin
				key_we = 1'b1;
				dat_we = 1'b1;
				if (count_q != '0) begin
					old_we = 1'b1; old_wa = free_q; old_wd = mru_q;
					new_we = 1'b1; new_wa = mru_q;  new_wd = free_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= lrucc_pkg::ST_IDLE;
			cap_q        <= lrucc_pkg::CAP_RESET;
			valid_q      <= '0;
			mru_q        <= '0;
			lru_q        <= '0;
			count_q      <= '0;
			total_q      <= '0;
			repl_q       <= '0;
			cmp_s1       <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_nx;
			cmp_s1  <= (state_q == lrucc_pkg::ST_SCAN);
			if (cfg_valid && cfg_ready) cap_q <= cfg_data;
			if (out_load) out_valid_q <= 1'b1;
			else if (m_axis_tvalid && m_axis_tready) out_valid_q <= 1'b0;
			case (state_q)
				lrucc_pkg::ST_DECIDE: begin
					if (!found_q && op_q == lrucc_pkg::OP_STORE
					    && (count_q == '0 || !bytes_full))
						total_q <= sum[lrucc_pkg::TOTAL_W] ? '1 : sum[lrucc_pkg::TOTAL_W-1:0];
				end
				lrucc_pkg::ST_HIT_FIX: begin
					if (slot_q != mru_q && slot_q == lru_q) lru_q <= new_rd;
				end
				lrucc_pkg::ST_HIT_LINK: begin
					mru_q  <= slot_q;
					repl_q <= repl_q + 1'b1;
				end
				lrucc_pkg::ST_EV_FIX: begin
					if (count_q > CW'(1)) lru_q <= new_rd;
					valid_q[lru_q] <= 1'b0;
					count_q <= count_q - 1'b1;
				end
				lrucc_pkg::ST_INS: begin
					valid_q[free_q] <= 1'b1;
					count_q <= count_q + 1'b1;
					mru_q   <= free_q;
					if (count_q == '0) lru_q <= free_q;
				end
				default: ;
			endcase
		end
	end

	// payload, scan and result bookkeeping
	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q;
		if (in_xfer) begin
			op_q         <= s_axis_tuser[0];
			key_q        <= s_axis_tdata[63:0];
			handle_q     <= s_axis_tdata[95:64];
			bytes_q      <= s_axis_tdata[115:96];
			cnt_q        <= '0;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
			res_hit_q    <= 1'b0;
			res_ev_q     <= 1'b0;
			res_handle_q <= '0;
			res_bytes_q  <= '0;
			res_evkey_q  <= '0;
		end
		if (state_q == lrucc_pkg::ST_SCAN) begin
			if (cnt_q != LAST) cnt_q <= cnt_q + 1'b1;
			if (!valid_q[cnt_q] && !free_found_q) begin
				free_found_q <= 1'b1;
				free_q       <= cnt_q;
			end
		end
		if (match && !found_q) begin
			found_q <= 1'b1;
			slot_q  <= idx_s1;
		end
		if (state_q == lrucc_pkg::ST_HIT_FIX) begin
			res_hit_q    <= 1'b1;
			res_handle_q <= dat_rd[lrucc_pkg::HANDLE_W-1:0];
			res_bytes_q  <= dat_rd[DW-1:lrucc_pkg::HANDLE_W];
		end
		if (state_q == lrucc_pkg::ST_EV_FIX) begin
			res_ev_q    <= 1'b1;
			res_evkey_q <= key_rd;
			// the vacated slot counts as free; keep the lowest one
			if (!free_found_q || lru_q < free_q) begin
				free_found_q <= 1'b1;
				free_q       <= lru_q;
			end
		end
		if (out_load) begin
			out_hit_q    <= res_hit_q;
			out_ev_q     <= res_ev_q;
			out_handle_q <= res_handle_q;
			out_bytes_q  <= res_bytes_q;
			out_evkey_q  <= res_evkey_q;
			out_repl_q   <= repl_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = {out_ev_q, out_hit_q};
	assign m_axis_tdata  = {4'd0, out_repl_q, out_evkey_q, out_bytes_q, out_handle_q};

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(ENTRIES)) else $error("entry count beyond slot total");

	a_count_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == int'(count_q)) else $error("entry count disagrees with valid bits");

	a_accept_scan: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> state_q == lrucc_pkg::ST_SCAN) else $error("accepted request did not scan");

	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> !m_axis_tuser[1]) else $error("hit with eviction");

	a_ins_has_slot: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == lrucc_pkg::ST_INS |-> free_found_q && !valid_q[free_q])
		else $error("insert without a free slot");

endmodule
`default_nettype wire

// File: sv/lrucc_ram.sv
`default_nettype none
module lrucc_ram #(
	parameter int unsigned W = 8,
	parameter int unsigned D = 64
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [$clog2(D)-1:0] waddr,
	input  wire logic [W-1:0]         wdata,
	input  wire logic [$clog2(D)-1:0] raddr,
	output logic      [W-1:0]         rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// File: dv/lru_content_cache_tb.sv
`default_nettype none
module lru_content_cache_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS = 64;
	localparam int KEY_POOL = 80;

	typedef struct packed {
		logic                           hit;
		logic [lrucc_pkg::HANDLE_W-1:0] hit_handle;
		logic [lrucc_pkg::BYTES_W-1:0]  hit_bytes;
		logic                           evicted;
		logic [lrucc_pkg::KEY_W-1:0]    evicted_key;
		logic [31:0]                    replace_count;
	} lookup_result_t;

	class cache_scoreboard;
		bit                             slot_valid[SLOTS];
		logic [lrucc_pkg::KEY_W-1:0]    slot_key[SLOTS];
		logic [lrucc_pkg::HANDLE_W-1:0] slot_handle[SLOTS];
		logic [lrucc_pkg::BYTES_W-1:0]  slot_bytes[SLOTS];
		int                             age_order[$];  // least recent first
		logic [lrucc_pkg::TOTAL_W-1:0]  byte_total;
		logic [31:0]                    replace_total;
		logic [lrucc_pkg::CAP_W-1:0]    capacity_kb;
		lookup_result_t                 pending[$];
		int                             errors;
		int                             checked;
		int                             hits;
		int                             evictions;

		function new();
			capacity_kb = lrucc_pkg::CAP_RESET;
			byte_total = '0;
			replace_total = '0;
			errors = 0;
			checked = 0;
			hits = 0;
			evictions = 0;
		endfunction

		// work out the result of one accepted request and update the cache image
		function void note_request(logic op, logic [lrucc_pkg::KEY_W-1:0] key,
			logic [lrucc_pkg::HANDLE_W-1:0] handle, logic [lrucc_pkg::BYTES_W-1:0] nbytes);
			lookup_result_t r;
			int found;
			int victim;
			int free_slot;
			bit bytes_full;
			bit was_empty;
			longint unsigned sum;
			r = '0;
			found = -1;
			for (int s = 0; s < SLOTS; s++) begin
				if (found < 0 && slot_valid[s] && slot_key[s] == key)
					found = s;
			end
			if (found >= 0) begin
				r.hit = 1'b1;
				r.hit_handle = slot_handle[found];
				r.hit_bytes = slot_bytes[found];
				if (age_order[$] != found) begin
					foreach (age_order[i]) begin
						if (age_order[i] == found) begin
							age_order.delete(i);
							break;
						end
					end
					age_order.push_back(found);
					replace_total++;
				end
			end else if (op == lrucc_pkg::OP_STORE) begin
				bytes_full = {16'd0, byte_total} >=
					({32'd0, capacity_kb} << lrucc_pkg::KB_SHIFT);
				was_empty = age_order.size() == 0;
				if (!was_empty && (bytes_full || age_order.size() >= SLOTS)) begin
					victim = age_order.pop_front();
					r.evicted = 1'b1;
					r.evicted_key = slot_key[victim];
					slot_valid[victim] = 1'b0;
				end
				if (was_empty || !bytes_full) begin
					sum = longint'(byte_total) + longint'(nbytes);
					byte_total = sum > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : sum[31:0];
				end
				free_slot = -1;
				for (int s = 0; s < SLOTS; s++) begin
					if (free_slot < 0 && !slot_valid[s])
						free_slot = s;
				end
				slot_valid[free_slot] = 1'b1;
				slot_key[free_slot] = key;
				slot_handle[free_slot] = handle;
				slot_bytes[free_slot] = nbytes;
				age_order.push_back(free_slot);
			end
			r.replace_count = replace_total;
			pending.push_back(r);
		endfunction

		task report(string what, logic [127:0] got, logic [127:0] want);
			errors++;
			$display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
		endtask

		task check_result(lookup_result_t got);
			lookup_result_t want;
			if (pending.size() == 0) begin
				report("unexpected result", got.hit, 0);
				return;
			end
			want = pending.pop_front();
			checked++;
			if (want.hit) hits++;
			if (want.evicted) evictions++;
			if (got.hit !== want.hit) report("hit", got.hit, want.hit);
			if (got.hit_handle !== want.hit_handle)
				report("hit_handle", got.hit_handle, want.hit_handle);
			if (got.hit_bytes !== want.hit_bytes)
				report("hit_bytes", got.hit_bytes, want.hit_bytes);
			if (got.evicted !== want.evicted) report("evicted", got.evicted, want.evicted);
			if (got.evicted_key !== want.evicted_key)
				report("evicted_key", got.evicted_key, want.evicted_key);
			if (got.replace_count !== want.replace_count)
				report("replacement_count", got.replace_count, want.replace_count);
		endtask
	endclass

	logic                              clk;
	logic                              arst_n;
	logic                              s_axis_tvalid;
	logic                              s_axis_tready;
	logic [lrucc_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
	logic [0:0]                        s_axis_tuser;
	logic                              m_axis_tvalid;
	logic                              m_axis_tready;
	logic [lrucc_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
	logic [1:0]                        m_axis_tuser;
	logic                              cfg_valid;
	logic                              cfg_ready;
	logic [lrucc_pkg::CAP_W-1:0]       cfg_data;

	cache_scoreboard sb = new();
	logic [lrucc_pkg::KEY_W-1:0] key_pool[KEY_POOL];
	int burst_left;
	int stall_mode;

	lru_content_cache #(.ENTRIES(SLOTS)) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// result side: check each transfer, then pick the next ready from the stall pattern
	always @(posedge clk) begin
		lookup_result_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.hit = m_axis_tuser[0];
			got.evicted = m_axis_tuser[1];
			got.hit_handle = m_axis_tdata[31:0];
			got.hit_bytes = m_axis_tdata[51:32];
			got.evicted_key = m_axis_tdata[115:52];
			got.replace_count = m_axis_tdata[147:116];
			sb.check_result(got);
		end
		if ($urandom_range(0, 199) == 0)
			stall_mode = $urandom_range(0, 3);
		case (stall_mode)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= $urandom_range(0, 3) != 0;
			2: m_axis_tready <= $urandom_range(0, 3) == 0;
			default: m_axis_tready <= $urandom_range(0, 30) == 0;
		endcase
	end

	task automatic send_request(logic op, logic [lrucc_pkg::KEY_W-1:0] key,
		logic [lrucc_pkg::HANDLE_W-1:0] handle, logic [lrucc_pkg::BYTES_W-1:0] nbytes);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40);
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= {4'd0, nbytes, handle, key};
		do @(posedge clk); while (!s_axis_tready);
		sb.note_request(op, key, handle, nbytes);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic write_capacity(logic [lrucc_pkg::CAP_W-1:0] kb);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= kb;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.capacity_kb = kb;
	endtask

	task automatic random_requests(int count);
		logic [lrucc_pkg::KEY_W-1:0] key;
		logic [lrucc_pkg::BYTES_W-1:0] nbytes;
		int pick;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 9);
			if (pick < 8)
				key = key_pool[$urandom_range(0, KEY_POOL - 1)];
			else
				key = {$urandom, $urandom};
			pick = $urandom_range(0, 9);
			if (pick < 6) nbytes = 20'($urandom_range(0, 4096));
			else if (pick < 9) nbytes = 20'($urandom);
			else nbytes = '1;
			send_request(1'($urandom_range(0, 1)), key, $urandom, nbytes);
			if (i == count / 2 && count > 100) drain();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		m_axis_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		burst_left = 0;
		stall_mode = 0;
		foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty cache, then key and field extremes, hits on old and newest entry
		send_request(lrucc_pkg::OP_LOOKUP, '0, '1, '1);
		send_request(lrucc_pkg::OP_STORE, '0, '0, '0);
		send_request(lrucc_pkg::OP_STORE, '1, '1, '1);
		send_request(lrucc_pkg::OP_LOOKUP, '0, '0, '0);
		send_request(lrucc_pkg::OP_LOOKUP, '0, '0, '0);
		send_request(lrucc_pkg::OP_STORE, '1, 32'h1234_5678, 20'h5);
		send_request(lrucc_pkg::OP_LOOKUP, 64'h5555_5555_5555_5555, '0, '0);
		send_request(lrucc_pkg::OP_STORE, 64'hAAAA_AAAA_AAAA_AAAA, 32'hA5A5_A5A5, 20'hFFFFF);
		send_request(lrucc_pkg::OP_LOOKUP, '0, '0, '0);
		// capacity zero: each store miss into a non-empty cache evicts
		write_capacity(16'd0);
		send_request(lrucc_pkg::OP_STORE, 64'h1, 32'h1, 20'h1);
		send_request(lrucc_pkg::OP_STORE, 64'h2, 32'h2, 20'h2);
		send_request(lrucc_pkg::OP_LOOKUP, 64'h2, '0, '0);
		random_requests(150);

		write_capacity(16'hFFFF);
		random_requests(250);
		write_capacity(16'd1);
		random_requests(150);
		write_capacity(lrucc_pkg::CAP_RESET);
		random_requests(200);
		write_capacity(16'($urandom_range(1, 65534)));
		random_requests(190);

		drain();
		$display("Covered %0d results: %0d hits, %0d evictions, capacities 0, 1, 1024, 65535",
			sb.checked, sb.hits, sb.evictions);
		$display("and one random capacity, with random source gaps and sink stalls");
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#40ms;
		$display("Timeout after %0t", $realtime);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
`default_nettype wire

// File: filelist.f
sv/lrucc_pkg.sv
sv/lrucc_ram.sv
sv/lru_content_cache.sv
dv/lru_content_cache_tb.sv
